>>> src/csvt_pkg.sv
// Shared constants and types for the CSV record tokenizer.
package csvt_pkg;

    // Byte codes
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] DELIM_RESET = 8'h2C;

    // One result word
    typedef struct packed {
        logic [7:0] field_byte;
        logic       byte_valid;
        logic       end_of_field;
        logic       end_of_record;
    } t_result;

    // Parser state flags
    typedef struct packed {
        logic in_quoted_section;
        logic quote_pending;
        logic cr_pending;
        logic record_open;
    } t_flags;

endpackage

>>> src/csvt_parse.sv
// Parser state flags and the per-byte decode that produces one result word.
module csvt_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,          // consume the word at the input
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_input,
    input  logic [7:0]        i_delim,
    output logic              o_has_result,
    output csvt_pkg::t_result o_result
);
    import csvt_pkg::*;

    t_flags r_flags;
    t_flags n_flags;

    // Decode one word against the current flags
    always_comb begin
        logic quoted;
        logic done;
        n_flags      = r_flags;
        o_has_result = 1'b0;
        o_result     = '0;
        quoted       = r_flags.in_quoted_section;
        done         = 1'b0;
        if (i_end_of_input) begin
            // flush: close an open record, then back to line start
            n_flags = '0;
            if (r_flags.record_open) begin
                o_has_result           = 1'b1;
                o_result.end_of_field  = 1'b1;
                o_result.end_of_record = 1'b1;
            end
        end else begin
            n_flags.cr_pending = 1'b0;
            // LF of a CRLF pair is swallowed
            if (r_flags.cr_pending && i_text_byte == CH_LF) begin
                done = 1'b1;
            end
            // quote inside quotes: doubled quote or section close
            if (!done && r_flags.quote_pending) begin
                n_flags.quote_pending = 1'b0;
                if (i_text_byte == CH_QUOTE) begin
                    o_has_result        = 1'b1;
                    o_result.field_byte = CH_QUOTE;
                    o_result.byte_valid = 1'b1;
                    done                = 1'b1;
                end else begin
                    quoted = 1'b0;
                end
            end
            if (!done) begin
                if (quoted) begin
                    n_flags.record_open = 1'b1;
                    if (i_text_byte == CH_QUOTE) begin
                        n_flags.quote_pending = 1'b1;
                    end else begin
                        o_has_result        = 1'b1;
                        o_result.field_byte = i_text_byte;
                        o_result.byte_valid = 1'b1;
                    end
                end else begin
                    n_flags.in_quoted_section = 1'b0;
                    if (i_text_byte == CH_QUOTE) begin
                        n_flags.in_quoted_section = 1'b1;
                        n_flags.record_open       = 1'b1;
                    end else if (i_text_byte == CH_CR || i_text_byte == CH_LF) begin
                        n_flags.record_open    = 1'b0;
                        n_flags.cr_pending     = (i_text_byte == CH_CR);
                        o_has_result           = 1'b1;
                        o_result.end_of_field  = 1'b1;
                        o_result.end_of_record = 1'b1;
                    end else begin
                        n_flags.record_open = 1'b1;
                        o_has_result        = 1'b1;
                        if (i_text_byte == i_delim) begin
                            o_result.end_of_field = 1'b1;
                        end else begin
                            o_result.field_byte = i_text_byte;
                            o_result.byte_valid = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // State flags advance only when a word is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_take) begin
            r_flags <= n_flags;
        end
    end

    // A pending quote only exists inside a quoted section
    a_qp_in_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.quote_pending |-> r_flags.in_quoted_section)
        else $error("quote pending outside quoted section");

    // A record-ending CR leaves the line closed and outside quotes
    a_cr_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.cr_pending |-> (!r_flags.record_open && !r_flags.in_quoted_section))
        else $error("cr pending with open record or quotes");

    // End of input returns all flags to line start
    a_eoi_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_end_of_input) |=> (r_flags == '0))
        else $error("flags not cleared after end of input");

    // End of record always comes with end of field
    a_eor_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_has_result && o_result.end_of_record) |-> o_result.end_of_field)
        else $error("end of record without end of field");

endmodule

>>> src/csv_record_tokenizer.sv
// Top level: input word register, parser, result register and delimiter register.
// An accepted word is held in the input word register, decoded by the parser and
// then held in the result register, which drives the master side.
// Throughput: one word per cycle; ready follows the result register's free slot.
// Reset (i_rst_n low, synchronous) empties both registers, clears the parser
// flags and loads the delimiter with a comma.
module csv_record_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0] i_s_axis_tuser,   // [0] end_of_input
    // result words
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] field_byte
    output logic [1:0] o_m_axis_tuser,   // [0] byte_valid, [1] end_of_field
    output logic       o_m_axis_tlast,   // end_of_record
    // delimiter register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import csvt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_delim;

    logic       w_out_free;
    logic       w_take;
    logic       w_has_result;
    t_result    w_result;

    // Handshake: input stage moves when the result register can take it
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_take          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign o_cfg_ready     = 1'b1;

    // Input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eoi  <= i_s_axis_tuser[0];
        end
    end

    // Delimiter register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (i_cfg_valid) begin
            r_delim <= i_cfg_data;
        end
    end

    csvt_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_text_byte    (r_in_byte),
        .i_end_of_input (r_in_eoi),
        .i_delim        (r_delim),
        .o_has_result   (w_has_result),
        .o_result       (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_take && w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out.field_byte;
    assign o_m_axis_tuser[0] = r_out.byte_valid;
    assign o_m_axis_tuser[1] = r_out.end_of_field;
    assign o_m_axis_tlast    = r_out.end_of_record;

endmodule
